// ===== rtl/core/sls_pkg.sv =====
// shared types and constants for the sequential list store
package sls_pkg;

	localparam int OP_W   = 3;
	localparam int POS_W  = 9;
	localparam int VAL_W  = 32;
	localparam int ST_W   = 3;
	localparam int FIDX_W = 8;
	localparam int CNT_W  = 9;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_POP_BACK   = 3'd1,
		OP_PUSH_FRONT = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_INSERT     = 3'd4,
		OP_ERASE      = 3'd5,
		OP_FIND       = 3'd6,
		OP_READ       = 3'd7
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_FIND,
		S_READ,
		S_DRAIN,
		S_COMMIT,
		S_FINISH
	} state_t;

	// what a memory read in flight is for
	typedef enum logic [1:0] {
		RK_UP,
		RK_DN,
		RK_FIND,
		RK_READ
	} rd_kind_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_TOP,
		CUR_POS,
		CUR_NEXT,
		CUR_ZERO,
		CUR_INC,
		CUR_DEC
	} cur_op_t;

	typedef struct packed {
		logic     load;
		cur_op_t  cur_op;
		logic     rd_en;
		rd_kind_t rd_kind;
		logic     place;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     res_load;
		status_t  res_status;
		logic     show_found;
		logic     show_read;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic pos_gt;
		logic pos_eq;
		logic pos_last;
		logic cur_at_pos;
		logic cur_last;
		logic hit;
	} dp_stat_t;

endpackage

// ===== rtl/core/sls_if.sv =====
// request and result channel interfaces of the list store
interface sls_req_if import sls_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, op, position, value, input ready);
	modport sink (input valid, op, position, value, output ready);
endinterface

interface sls_rsp_if import sls_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic [FIDX_W-1:0]       found_index;
	logic signed [VAL_W-1:0] read_value;
	logic [CNT_W-1:0]        entry_count;
	logic                    is_empty;

	modport source (output valid, status, found_index, read_value, entry_count, is_empty,
		input ready);
	modport sink (input valid, status, found_index, read_value, entry_count, is_empty,
		output ready);
endinterface

// ===== rtl/core/sequential_list_store.sv =====
// push_back, pop_back and positions at the tail commit without a shift; insert/push_front shift the
// entries from position to the tail up, erase/pop_front shift them down; find scans up to count
// entries and read fetches one entry; the shift and scan walk one entry per
// cycle through the single read and single write port of the entry memory
// one request is worked at a time; a finished result waits in its own register
// reset clears the entry count and control state only, the entry memory is not cleared
module sequential_list_store import sls_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic clk,
	input  logic arst_n,
	sls_req_if.sink   req,
	sls_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// controller: sequences decide, shift or scan, commit and result hand-off
	sls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_op    (req.op),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: entry memory, count, cursor, one-deep read stage, result registers
	sls_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_op           (req.op),
		.in_position     (req.position),
		.in_value        (req.value),
		.res_status      (rsp.status),
		.res_found_index (rsp.found_index),
		.res_read_value  (rsp.read_value),
		.res_entry_count (rsp.entry_count),
		.res_is_empty    (rsp.is_empty)
	);

endmodule

// ===== rtl/core/sls_datapath.sv =====
// list storage, count, cursor, read stage and result registers
module sls_datapath import sls_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	input  logic [OP_W-1:0]         in_op,
	input  logic [POS_W-1:0]        in_position,
	input  logic signed [VAL_W-1:0] in_value,
	output logic [ST_W-1:0]         res_status,
	output logic [FIDX_W-1:0]       res_found_index,
	output logic signed [VAL_W-1:0] res_read_value,
	output logic [CNT_W-1:0]        res_entry_count,
	output logic                    res_is_empty
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > POS_W) ? CW : POS_W;

	logic signed [VAL_W-1:0] mem [CAPACITY];

	logic [CW-1:0]           count_q;
	logic [LW-1:0]           pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic [AW-1:0]           cur_q;
	logic                    hit_q;
	logic [AW-1:0]           found_q;
	logic signed [VAL_W-1:0] rd_q;

	logic                    rvld_s1;
	rd_kind_t                kind_s1;
	logic [AW-1:0]           raddr_s1;
	logic signed [VAL_W-1:0] rdata_s1;

	logic [LW-1:0]           pos_eff;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic signed [VAL_W-1:0] wr_data;

	// pushes and pops are inserts and erases at a derived position
	always_comb begin
		case (op_t'(in_op))
			OP_PUSH_BACK:  pos_eff = LW'(count_q);
			OP_POP_BACK:   pos_eff = LW'(count_q) - LW'(1);
			OP_PUSH_FRONT: pos_eff = '0;
			OP_POP_FRONT:  pos_eff = '0;
			default:       pos_eff = LW'(in_position);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= pos_eff;
			val_q <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.cur_op)
			CUR_TOP:  cur_q <= AW'(count_q - CW'(1));
			CUR_POS:  cur_q <= pos_q[AW-1:0];
			CUR_NEXT: cur_q <= AW'(pos_q + LW'(1));
			CUR_ZERO: cur_q <= '0;
			CUR_INC:  cur_q <= cur_q + AW'(1);
			CUR_DEC:  cur_q <= cur_q - AW'(1);
			default:  cur_q <= cur_q;
		endcase
	end

	// single write port: shifted word from the read stage or the new word
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = val_q;
		if (cmd.place) begin
			wr_en = 1'b1;
		end else if (rvld_s1 && kind_s1 == RK_UP) begin
			wr_en   = 1'b1;
			wr_addr = raddr_s1 + AW'(1);
			wr_data = rdata_s1;
		end else if (rvld_s1 && kind_s1 == RK_DN) begin
			wr_en   = 1'b1;
			wr_addr = raddr_s1 - AW'(1);
			wr_data = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			kind_s1  <= cmd.rd_kind;
			raddr_s1 <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			rvld_s1 <= cmd.rd_en;
			if (cmd.load) begin
				hit_q <= 1'b0;
			end else if (rvld_s1 && kind_s1 == RK_FIND && rdata_s1 == val_q) begin
				hit_q <= 1'b1;
			end
		end
	end

	// first match only
	always_ff @(posedge clk) begin
		if (rvld_s1 && kind_s1 == RK_FIND && rdata_s1 == val_q && !hit_q) begin
			found_q <= raddr_s1;
		end
		if (rvld_s1 && kind_s1 == RK_READ) begin
			rd_q <= rdata_s1;
		end
	end

	always_comb begin
		stat.empty      = (count_q == '0);
		stat.full       = (count_q == CW'(CAPACITY));
		stat.pos_gt     = (pos_q > LW'(count_q));
		stat.pos_eq     = (pos_q == LW'(count_q));
		stat.pos_last   = ((LW+1)'(pos_q) + (LW+1)'(1)) == (LW+1)'(count_q);
		stat.cur_at_pos = (LW'(cur_q) == pos_q);
		stat.cur_last   = ((CW'(cur_q) + CW'(1)) == count_q);
		stat.hit        = hit_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status      <= cmd.res_status;
			res_found_index <= cmd.show_found ? FIDX_W'(found_q) : '0;
			res_read_value  <= cmd.show_read ? rd_q : '0;
			res_entry_count <= CNT_W'(count_q);
			res_is_empty    <= (count_q == '0);
		end
	end

endmodule

// ===== rtl/core/sls_ctrl.sv =====
// sequencer that steps each request through decide, any walk or commit that it needs, and finish
module sls_ctrl import sls_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [OP_W-1:0] req_op,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  dp_stat_t        stat,
	output dp_cmd_t         cmd
);

	state_t  state_q, state_nx;
	op_t     op_q;
	status_t status_q, status_nx;
	logic    out_vld_q;
	logic    is_ins, is_ers, is_find, is_read;

	always_comb begin
		is_ins  = (op_q == OP_PUSH_BACK) || (op_q == OP_PUSH_FRONT) || (op_q == OP_INSERT);
		is_ers  = (op_q == OP_POP_BACK) || (op_q == OP_POP_FRONT) || (op_q == OP_ERASE);
		is_find = (op_q == OP_FIND);
		is_read = (op_q == OP_READ);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nx = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (is_ins) begin
					if (stat.full || stat.pos_gt) begin
						state_nx = S_FINISH;
					end else if (stat.pos_eq) begin
						state_nx = S_COMMIT;
					end else begin
						state_nx = S_SHIFT_UP;
					end
				end else if (is_ers) begin
					if (stat.empty || stat.pos_gt || stat.pos_eq) begin
						state_nx = S_FINISH;
					end else if (stat.pos_last) begin
						state_nx = S_COMMIT;
					end else begin
						state_nx = S_SHIFT_DN;
					end
				end else if (is_find) begin
					state_nx = stat.empty ? S_FINISH : S_FIND;
				end else begin
					if (stat.empty || stat.pos_gt || stat.pos_eq) begin
						state_nx = S_FINISH;
					end else begin
						state_nx = S_READ;
					end
				end
			end
			S_SHIFT_UP: begin
				if (stat.cur_at_pos) begin
					state_nx = S_DRAIN;
				end
			end
			S_SHIFT_DN: begin
				if (stat.cur_last) begin
					state_nx = S_DRAIN;
				end
			end
			S_FIND: begin
				if (stat.hit) begin
					state_nx = S_FINISH;
				end else if (stat.cur_last) begin
					state_nx = S_DRAIN;
				end
			end
			S_READ:   state_nx = S_DRAIN;
			S_DRAIN:  state_nx = (is_ins || is_ers) ? S_COMMIT : S_FINISH;
			S_COMMIT: state_nx = S_FINISH;
			S_FINISH: begin
				if (!out_vld_q || rsp_ready) begin
					state_nx = S_IDLE;
				end
			end
			default:  state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.cur_op     = CUR_HOLD;
		cmd.rd_kind    = RK_UP;
		cmd.res_status = ST_OK;
		status_nx      = status_q;
		req_ready      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_DECIDE: begin
				status_nx = ST_OK;
				if (is_ins) begin
					if (stat.full) begin
						status_nx = ST_FULL;
					end else if (stat.pos_gt) begin
						status_nx = ST_BADPOS;
					end else if (!stat.pos_eq) begin
						cmd.cur_op = CUR_TOP;
					end
				end else if (is_ers) begin
					if (stat.empty) begin
						status_nx = ST_EMPTY;
					end else if (stat.pos_gt || stat.pos_eq) begin
						status_nx = ST_BADPOS;
					end else if (!stat.pos_last) begin
						cmd.cur_op = CUR_NEXT;
					end
				end else if (is_find) begin
					status_nx  = ST_NOTFOUND;
					cmd.cur_op = CUR_ZERO;
				end else begin
					if (stat.empty) begin
						status_nx = ST_EMPTY;
					end else if (stat.pos_gt || stat.pos_eq) begin
						status_nx = ST_BADPOS;
					end else begin
						cmd.cur_op = CUR_POS;
					end
				end
			end
			S_SHIFT_UP: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_kind = RK_UP;
				cmd.cur_op  = stat.cur_at_pos ? CUR_HOLD : CUR_DEC;
			end
			S_SHIFT_DN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_kind = RK_DN;
				cmd.cur_op  = stat.cur_last ? CUR_HOLD : CUR_INC;
			end
			S_FIND: begin
				if (!stat.hit) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_kind = RK_FIND;
					cmd.cur_op  = stat.cur_last ? CUR_HOLD : CUR_INC;
				end
			end
			S_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_kind = RK_READ;
			end
			S_DRAIN: begin
			end
			S_COMMIT: begin
				cmd.place   = is_ins;
				cmd.cnt_inc = is_ins;
				cmd.cnt_dec = is_ers;
			end
			S_FINISH: begin
				cmd.res_load   = !out_vld_q || rsp_ready;
				cmd.res_status = (is_find && stat.hit) ? ST_OK : status_q;
				cmd.show_found = is_find && stat.hit;
				cmd.show_read  = is_read && (status_q == ST_OK);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_PUSH_BACK;
			status_q  <= ST_OK;
			out_vld_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			status_q <= status_nx;
			if (cmd.load) begin
				op_q <= op_t'(req_op);
			end
			if (cmd.res_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_vld_q;

endmodule

// ===== tb/sv/sequential_list_store_tb.sv =====
// self-checking testbench for the sequential list store: directed requests, then random traffic
module sequential_list_store_tb import sls_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH   = 256;
	localparam int PHASE_REQS   = 345;   // random requests per idling phase
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off in the last phase
	localparam int STALL_LIMIT  = 4000;  // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 300;   // one full walk of the list plus margin
	localparam int MAX_REPORTS  = 10;

	// one result as the block reports it
	typedef struct packed {
		status_t             status;
		logic [FIDX_W-1:0]   found_index;
		logic [VAL_W-1:0]    read_value;
		logic [CNT_W-1:0]    entry_count;
		logic                is_empty;
	} list_result_t;

	// shadow copy of the list, updated in request order, plus the results it owes
	class list_scoreboard;
		logic [VAL_W-1:0] words [LIST_DEPTH];
		int unsigned      fill;
		list_result_t     owed_q[$];
		int unsigned      mismatches;

		function new();
			fill       = 0;
			mismatches = 0;
		endfunction

		// apply one accepted request to the shadow list and queue its result
		function void note_request(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
			list_result_t r;
			int unsigned  i;
			r = '0;
			r.status = ST_OK;
			case (op)
				OP_PUSH_BACK: begin
					if (fill >= LIST_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						words[fill] = val;
						fill++;
					end
				end
				OP_POP_BACK: begin
					if (fill == 0) r.status = ST_EMPTY;
					else fill--;
				end
				OP_PUSH_FRONT: begin
					if (fill >= LIST_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						for (i = fill; i > 0; i--) words[i] = words[i-1];
						words[0] = val;
						fill++;
					end
				end
				OP_POP_FRONT: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						for (i = 1; i < fill; i++) words[i-1] = words[i];
						fill--;
					end
				end
				OP_INSERT: begin
					if (fill >= LIST_DEPTH) begin
						r.status = ST_FULL;
					end else if (pos > fill) begin
						r.status = ST_BADPOS;
					end else begin
						for (i = fill; i > pos; i--) words[i] = words[i-1];
						words[pos] = val;
						fill++;
					end
				end
				OP_ERASE: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else if (pos >= fill) begin
						r.status = ST_BADPOS;
					end else begin
						for (i = pos + 1; i < fill; i++) words[i-1] = words[i];
						fill--;
					end
				end
				OP_FIND: begin
					r.status = ST_NOTFOUND;
					for (i = 0; i < fill; i++) begin
						if (words[i] == val) begin
							r.status      = ST_OK;
							r.found_index = i[FIDX_W-1:0];
							break;
						end
					end
				end
				default: begin
					if (fill == 0) r.status = ST_EMPTY;
					else if (pos >= fill) r.status = ST_BADPOS;
					else r.read_value = words[pos];
				end
			endcase
			r.entry_count = fill[CNT_W-1:0];
			r.is_empty    = (fill == 0);
			owed_q.push_back(r);
		endfunction

		function void report(string why, list_result_t want, list_result_t got);
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t %s: want st=%0d idx=%0d rd=%h cnt=%0d emp=%0d",
					$realtime, why, want.status, want.found_index, want.read_value,
					want.entry_count, want.is_empty);
				$display("%0t %s: got  st=%0d idx=%0d rd=%h cnt=%0d emp=%0d",
					$realtime, why, got.status, got.found_index, got.read_value,
					got.entry_count, got.is_empty);
			end
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (owed_q.size() == 0) begin
				report("result with nothing owed", '0, got);
			end else begin
				want = owed_q.pop_front();
				if (want !== got) report("result mismatch", want, got);
			end
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sls_req_if req_ch ();
	sls_rsp_if rsp_ch ();

	sequential_list_store #(.CAPACITY(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_scoreboard board = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_start;      // raised by the sender side, consumed by the receiver
	bit          growing = 1'b1;  // random traffic leans toward filling, else draining
	int unsigned quiet_cycles;

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// drive one request at a falling edge and hold it until the block takes it
	task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.position <= pos;
		req_ch.value    <= val;
		do @(posedge clk); while (!req_ch.ready);
		board.note_request(op, pos, val);
	endtask

	// random word: mostly full range, sometimes small values of either sign for duplicates
	function automatic logic [VAL_W-1:0] pick_word();
		logic [VAL_W-1:0] w;
		if ($urandom_range(3) == 0) begin
			w = $urandom_range(15);
			if ($urandom_range(1)) w = ~w;
		end else begin
			w = $urandom();
		end
		return w;
	endfunction

	// one random request shaped by the current fill level and direction
	task automatic random_request();
		int unsigned      n;
		int unsigned      pick;
		op_t              op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		n   = board.fill;
		val = pick_word();
		// flip direction after lingering a while at full or at empty
		if (growing && n == LIST_DEPTH && $urandom_range(7) == 0) growing = 1'b0;
		else if (!growing && n == 0 && $urandom_range(3) == 0) growing = 1'b1;
		if ($urandom_range(99) < 8) begin
			// noise: anything at any position
			op  = op_t'($urandom_range(7));
			pos = POS_W'($urandom_range(LIST_DEPTH));
		end else begin
			pick = $urandom_range(99);
			if (growing) begin
				if (pick < 30) op = OP_PUSH_BACK;
				else if (pick < 45) op = OP_PUSH_FRONT;
				else if (pick < 72) op = OP_INSERT;
				else if (pick < 77) op = op_t'($urandom_range(1) ? OP_ERASE : OP_POP_BACK);
				else if (pick < 88) op = OP_FIND;
				else op = OP_READ;
			end else begin
				if (pick < 25) op = OP_ERASE;
				else if (pick < 40) op = OP_POP_FRONT;
				else if (pick < 62) op = OP_POP_BACK;
				else if (pick < 67) op = op_t'($urandom_range(1) ? OP_INSERT : OP_PUSH_FRONT);
				else if (pick < 80) op = OP_FIND;
				else op = OP_READ;
			end
			// positions are mostly legal for the current fill, sometimes past the end
			if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(LIST_DEPTH));
			else if (op == OP_INSERT) pos = POS_W'($urandom_range(n));
			else pos = (n > 0) ? POS_W'($urandom_range(n - 1)) : '0;
			// most searches look for a word that is actually stored
			if (op == OP_FIND && n > 0 && $urandom_range(9) < 6)
				val = board.words[$urandom_range(n - 1)];
		end
		send_request(op, pos, val);
	endtask

	// result side: ready changes on the falling edge, long hold-off on demand
	initial begin
		int unsigned hold_left;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// every taken result goes against the oldest owed one
	always @(posedge clk) begin
		list_result_t got;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got.status      = status_t'(rsp_ch.status);
			got.found_index = rsp_ch.found_index;
			got.read_value  = rsp_ch.read_value;
			got.entry_count = rsp_ch.entry_count;
			got.is_empty    = rsp_ch.is_empty;
			board.check_result(got);
		end
	end

	// watchdog: too long without any handshake on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.op       = OP_PUSH_BACK;
		req_ch.position = '0;
		req_ch.value    = '0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		hold_start      = 1'b0;
		quiet_cycles    = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed: pops, erase, read and find on an empty list
		send_idle_pct = 20;
		recv_idle_pct = 20;
		send_request(OP_POP_BACK, 9'd0, 32'd0);
		send_request(OP_POP_FRONT, 9'd0, 32'd0);
		send_request(OP_ERASE, 9'd0, 32'd0);
		send_request(OP_READ, 9'd0, 32'd0);
		send_request(OP_FIND, 9'd0, 32'd0);
		// insert past the end of an empty list
		send_request(OP_INSERT, 9'd1, 32'd5);
		// extreme words at the front, back and middle
		send_request(OP_INSERT, 9'd0, 32'h8000_0000);
		send_request(OP_PUSH_BACK, 9'd0, 32'h7FFF_FFFF);
		send_request(OP_PUSH_FRONT, 9'd0, 32'hFFFF_FFFF);
		// insert at position equal to the count appends
		send_request(OP_INSERT, 9'd3, 32'h0000_0000);
		send_request(OP_INSERT, 9'd2, 32'h5A5A_A5A5);
		send_request(OP_READ, 9'd0, 32'd0);
		send_request(OP_READ, 9'd4, 32'd0);
		// positions at and far past the end
		send_request(OP_READ, 9'd5, 32'd0);
		send_request(OP_READ, 9'd256, 32'd0);
		send_request(OP_ERASE, 9'd256, 32'd0);
		send_request(OP_INSERT, 9'd256, 32'd1);
		// find: hit, miss, and first of two matches
		send_request(OP_FIND, 9'd0, 32'h7FFF_FFFF);
		send_request(OP_FIND, 9'd0, 32'h1234_5678);
		send_request(OP_PUSH_BACK, 9'd0, 32'hFFFF_FFFF);
		send_request(OP_FIND, 9'd0, 32'hFFFF_FFFF);
		send_request(OP_ERASE, 9'd1, 32'd0);
		send_request(OP_POP_FRONT, 9'd0, 32'd0);
		send_request(OP_POP_BACK, 9'd0, 32'd0);

		// random traffic in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < PHASE_REQS; k++) begin
				random_request();
				// back up the block: results stall while requests keep coming
				if (ph == 2 && k == 0) hold_start = 1'b1;
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (board.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
